// ===== rtl/klf_pkg.sv =====
// klf_pkg: types and constants shared by the keyword line filter modules
// item formats, command kinds, result fields and register map
// no dependencies
`default_nettype none

package klf_pkg;

	// fixed field widths of the item and result ports
	localparam int OPCODE_W = 2;
	localparam int BYTE_W   = 8;
	localparam int SLOT_W   = 3;
	localparam int POS_W    = 4;
	localparam int KLEN_W   = 5;
	localparam int START_W  = 17;
	localparam int LENGTH_W = 18;

	// input opcodes
	localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CHAR = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_LEN  = 2'd2;

	// configuration register map, selected by paddr[2]
	localparam int           PADDR_W    = 3;
	localparam int           PDATA_W    = 32;
	localparam int           ACTIVE_W   = 4;
	localparam logic         REG_ACTIVE = 1'b0;
	localparam logic         REG_TERM   = 1'b1;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd0;
	localparam logic [BYTE_W-1:0]   TERM_RESET   = 8'd10;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_CHAR,
		CMD_LEN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [BYTE_W-1:0]  data;
		logic               eob;
		logic [SLOT_W-1:0]  slot;
		logic [POS_W-1:0]   pos;
		logic [KLEN_W-1:0]  klen;
	} cmd_t;

	typedef struct packed {
		logic [ACTIVE_W-1:0] active_keywords;
		logic [BYTE_W-1:0]   line_terminator;
	} cfg_t;

	typedef struct packed {
		logic [START_W-1:0]  line_start;
		logic [LENGTH_W-1:0] line_length;
		logic                hide_line;
		logic                last_line;
		logic                buffer_modified;
		logic                overflow;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/klf_front.sv =====
// klf_front: accepts input items, classifies them and queues the ones that do work
// two-entry command queue towards the matcher back end
// depends on klf_pkg
`default_nettype none

module klf_front #(
	parameter int KEYWORDS = 8,
	parameter int KEY_LEN  = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire [klf_pkg::OPCODE_W-1:0]  opcode,
	input  wire [klf_pkg::BYTE_W-1:0]    byte_value,
	input  wire                          end_of_buffer,
	input  wire [klf_pkg::SLOT_W-1:0]    keyword_slot,
	input  wire [klf_pkg::POS_W-1:0]     char_position,
	input  wire [klf_pkg::KLEN_W-1:0]    keyword_length,
	output logic                         cmd_valid,
	output klf_pkg::cmd_t                cmd,
	input  wire                          cmd_pop
);
	import klf_pkg::*;

	localparam int DEPTH = 2;

	cmd_t        queue_q [DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        slot_ok;
	logic        pos_ok;
	logic        keep;
	logic        wr;
	cmd_t        cls;

	// out-of-range writes and unknown opcodes are dropped here
	always_comb begin
		slot_ok = int'(keyword_slot) < KEYWORDS;
		pos_ok  = int'(char_position) < KEY_LEN;
		cls.data = byte_value;
		cls.eob  = end_of_buffer;
		cls.slot = keyword_slot;
		cls.pos  = char_position;
		cls.klen = keyword_length;
		unique case (opcode)
			OP_BYTE: begin
				cls.kind = CMD_BYTE;
				keep     = 1'b1;
			end
			OP_CHAR: begin
				cls.kind = CMD_CHAR;
				keep     = slot_ok && pos_ok;
			end
			OP_LEN: begin
				cls.kind = CMD_LEN;
				keep     = slot_ok;
			end
			default: begin
				cls.kind = CMD_BYTE;
				keep     = 1'b0;
			end
		endcase
	end

	assign full      = cnt_q == 2'(DEPTH);
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = queue_q[rd_ptr_q];
	assign wr        = push && !full && keep;

	always_ff @(posedge clk) begin
		if (wr) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({wr, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/klf_back.sv =====
// klf_back: keyword store, shift-and matchers, line tracking and result queue
// takes classified commands from klf_front, one per cycle while the result queue has room
// depends on klf_pkg
`default_nettype none

module klf_back #(
	parameter int KEYWORDS  = 8,
	parameter int KEY_LEN   = 16,
	parameter int MAX_BYTES = 131072
) (
	input  wire            clk,
	input  wire            arst_n,
	input  klf_pkg::cfg_t  cfg,
	input  wire            cmd_valid,
	input  klf_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           res_empty,
	output klf_pkg::res_t  res,
	input  wire            res_pop
);
	import klf_pkg::*;

	localparam int IDX_W   = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;
	localparam int CPOS_W  = $clog2(KEY_LEN);
	localparam int LEN_W   = $clog2(KEY_LEN + 1);
	localparam int OFF_W   = $clog2(MAX_BYTES + 1);
	localparam int RDEPTH  = 2;

	logic [BYTE_W-1:0]  kw_chars_q [KEYWORDS][KEY_LEN];
	logic [KLEN_W-1:0]  kw_len_q   [KEYWORDS];
	logic [KEY_LEN-1:0] match_q    [KEYWORDS];
	logic               line_hit_q;
	logic               any_hit_q;
	logic               overflowed_q;
	logic [OFF_W-1:0]   byte_offset_q;
	logic [OFF_W-1:0]   cur_start_q;

	res_t               rqueue_q [RDEPTH];
	logic               rwr_ptr_q;
	logic               rrd_ptr_q;
	logic [1:0]         rcnt_q;

	logic [LEN_W-1:0]   eff_len [KEYWORDS];
	logic [KEY_LEN-1:0] next_vec [KEYWORDS];
	logic [KEY_LEN-1:0] prev_vec [KEYWORDS];
	logic [KEY_LEN-1:0] end_mask [KEYWORDS];
	logic [KEYWORDS-1:0] slot_hit;
	logic               active_hit;
	logic               line_hit_new;
	logic               over;
	logic               overflowed_new;
	logic [OFF_W-1:0]   here;
	logic [OFF_W-1:0]   here_inc;
	logic               is_byte;
	logic               line_end;
	logic               emit;
	res_t               res_new;

	assign cmd_pop = cmd_valid && (rcnt_q != 2'(RDEPTH));
	assign is_byte = cmd_pop && (cmd.kind == CMD_BYTE);

	// every slot advances on every stream byte; only active slots flag the line
	always_comb begin
		for (int s = 0; s < KEYWORDS; s++) begin
			eff_len[s]  = (int'(kw_len_q[s]) > KEY_LEN) ? LEN_W'(KEY_LEN) : LEN_W'(kw_len_q[s]);
			prev_vec[s] = {match_q[s][KEY_LEN-2:0], 1'b1};
			for (int i = 0; i < KEY_LEN; i++) begin
				next_vec[s][i] = prev_vec[s][i] && (LEN_W'(i) < eff_len[s]) &&
					(kw_chars_q[s][i] == cmd.data);
				end_mask[s][i] = eff_len[s] == LEN_W'(i + 1);
			end
			slot_hit[s] = (|(next_vec[s] & end_mask[s])) && (int'(cfg.active_keywords) > s);
		end
		active_hit = |slot_hit;
	end

	always_comb begin
		over           = byte_offset_q >= OFF_W'(MAX_BYTES);
		here           = over ? OFF_W'(MAX_BYTES - 1) : byte_offset_q;
		here_inc       = here + OFF_W'(1);
		overflowed_new = overflowed_q || over;
		line_hit_new   = line_hit_q || active_hit;
		line_end       = cmd.eob || (cmd.data == cfg.line_terminator);
		emit           = is_byte && line_end;

		res_new.line_start      = START_W'(cur_start_q);
		res_new.line_length     = LENGTH_W'(here - cur_start_q + OFF_W'(1));
		res_new.hide_line       = line_hit_new;
		res_new.last_line       = cmd.eob;
		res_new.buffer_modified = cmd.eob && (any_hit_q || line_hit_new);
		res_new.overflow        = overflowed_new;
	end

	// keyword characters have no reset
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.kind == CMD_CHAR)) begin
			kw_chars_q[IDX_W'(cmd.slot)][CPOS_W'(cmd.pos)] <= cmd.data;
		end
		if (emit) begin
			rqueue_q[rwr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < KEYWORDS; s++) begin
				kw_len_q[s] <= '1;
				match_q[s]  <= '0;
			end
			line_hit_q    <= 1'b0;
			any_hit_q     <= 1'b0;
			overflowed_q  <= 1'b0;
			byte_offset_q <= '0;
			cur_start_q   <= '0;
			rwr_ptr_q     <= 1'b0;
			rrd_ptr_q     <= 1'b0;
			rcnt_q        <= 2'd0;
		end else begin
			if (cmd_pop) begin
				unique case (cmd.kind)
					CMD_LEN: begin
						kw_len_q[IDX_W'(cmd.slot)] <= cmd.klen;
					end
					CMD_BYTE: begin
						if (line_end) begin
							for (int s = 0; s < KEYWORDS; s++) begin
								match_q[s] <= '0;
							end
							line_hit_q <= 1'b0;
							if (cmd.eob) begin
								byte_offset_q <= '0;
								cur_start_q   <= '0;
								any_hit_q     <= 1'b0;
								overflowed_q  <= 1'b0;
							end else begin
								byte_offset_q <= here_inc;
								cur_start_q   <= (here_inc == OFF_W'(MAX_BYTES)) ?
									OFF_W'(MAX_BYTES - 1) : here_inc;
								any_hit_q     <= any_hit_q || line_hit_new;
								overflowed_q  <= overflowed_new;
							end
						end else begin
							for (int s = 0; s < KEYWORDS; s++) begin
								match_q[s] <= next_vec[s];
							end
							line_hit_q    <= line_hit_new;
							byte_offset_q <= here_inc;
							overflowed_q  <= overflowed_new;
						end
					end
					default: begin
					end
				endcase
			end
			if (emit) begin
				rwr_ptr_q <= ~rwr_ptr_q;
			end
			if (res_pop && !res_empty) begin
				rrd_ptr_q <= ~rrd_ptr_q;
			end
			unique case ({emit, res_pop && !res_empty})
				2'b10:   rcnt_q <= rcnt_q + 2'd1;
				2'b01:   rcnt_q <= rcnt_q - 2'd1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

	assign res_empty = rcnt_q == 2'd0;
	assign res       = rqueue_q[rrd_ptr_q];

	// a finished line is waiting for the consumer on the next cycle
	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !res_empty)
		else $error("line result not queued");

	// end of buffer rewinds the offsets
	a_eob_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cmd.eob) |=> (byte_offset_q == '0) && (cur_start_q == '0))
		else $error("offsets not cleared at end of buffer");

	// a line never starts past the current byte offset
	a_start_order: assert property (@(posedge clk) disable iff (!arst_n)
		cur_start_q <= byte_offset_q)
		else $error("line start beyond byte offset");

endmodule

`default_nettype wire

// ===== rtl/keyword_line_filter.sv =====
// keyword_line_filter: top level with the configuration registers
// instantiates klf_front and klf_back
// depends on klf_pkg
`default_nettype none

// Line classifier for a byte stream. Stream bytes and keyword writes enter through the push/full
// queue port; each finished line leaves as one item on the empty/pop port, giving its offset,
// length, whether an active keyword occurred in it and, on the last line of a buffer, whether
// any line of the buffer was flagged. The block takes one item per cycle while the result queue
// has room: all keyword slots advance their shift-and vectors in parallel in the same cycle, so
// the sustained rate is one byte per clock while results are drained. A line result reaches the
// output once its last byte has left the two-entry command queue and the matcher has written
// its result into the result queue. full rises when the command queue holds two items, which
// happens only after the two-entry result queue has filled up: while it is full the matcher
// takes no item, even in a cycle where pop drains it. Keyword writes take
// effect on the following stream byte. There is no clearing pass after reset; keyword
// characters must be written before their slot is used.
// active_keywords sits at byte address 0 and line_terminator at 4; write them only while idle.
module keyword_line_filter #(
	parameter int KEYWORDS  = 8,
	parameter int KEY_LEN   = 16,
	parameter int MAX_BYTES = 131072
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [klf_pkg::PADDR_W-1:0]   paddr,
	input  wire [klf_pkg::PDATA_W-1:0]   pwdata,
	output logic [klf_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  wire                          push,
	output logic                         full,
	input  wire [klf_pkg::OPCODE_W-1:0]  opcode,
	input  wire [klf_pkg::BYTE_W-1:0]    byte_value,
	input  wire                          end_of_buffer,
	input  wire [klf_pkg::SLOT_W-1:0]    keyword_slot,
	input  wire [klf_pkg::POS_W-1:0]     char_position,
	input  wire [klf_pkg::KLEN_W-1:0]    keyword_length,
	output logic                         empty,
	input  wire                          pop,
	output logic [klf_pkg::START_W-1:0]  line_start,
	output logic [klf_pkg::LENGTH_W-1:0] line_length,
	output logic                         hide_line,
	output logic                         last_line,
	output logic                         buffer_modified,
	output logic                         overflow
);
	import klf_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	res_t  res;
	logic  cmd_valid;
	logic  cmd_pop;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_keywords <= ACTIVE_RESET;
			cfg_q.line_terminator <= TERM_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ACTIVE: cfg_q.active_keywords <= pwdata[ACTIVE_W-1:0];
				REG_TERM:   cfg_q.line_terminator <= pwdata[BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ACTIVE: prdata = PDATA_W'(cfg_q.active_keywords);
			REG_TERM:   prdata = PDATA_W'(cfg_q.line_terminator);
			default:    prdata = '0;
		endcase
	end

	klf_front #(
		.KEYWORDS (KEYWORDS),
		.KEY_LEN  (KEY_LEN)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.byte_value     (byte_value),
		.end_of_buffer  (end_of_buffer),
		.keyword_slot   (keyword_slot),
		.char_position  (char_position),
		.keyword_length (keyword_length),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	klf_back #(
		.KEYWORDS  (KEYWORDS),
		.KEY_LEN   (KEY_LEN),
		.MAX_BYTES (MAX_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_empty (empty),
		.res       (res),
		.res_pop   (pop)
	);

	assign line_start      = res.line_start;
	assign line_length     = res.line_length;
	assign hide_line       = res.hide_line;
	assign last_line       = res.last_line;
	assign buffer_modified = res.buffer_modified;
	assign overflow        = res.overflow;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for keyword_line_filter, driven through its item queue ports
// holds a line classifier of its own, a stimulus table, an overflow buffer and random phases
// depends on klf_pkg and keyword_line_filter
`default_nettype none

module tb_top;
	import klf_pkg::*;

	localparam int KW_SLOTS      = 8;
	localparam int KW_CHARS      = 16;
	localparam int MAX_BYTES     = 131072;
	localparam int SCRIPT_ROWS   = 19;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 275;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
	localparam logic [BYTE_W-1:0]   NEWLINE = 8'h0a;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [BYTE_W-1:0]   data;
		logic                eob;
		logic [SLOT_W-1:0]   slot;
		logic [POS_W-1:0]    pos;
		logic [KLEN_W-1:0]   klen;
	} item_t;

	typedef struct packed {
		item_t it;
		logic  typed;
		res_t  want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [BYTE_W-1:0]   byte_value = '0;
	logic                end_of_buffer = 1'b0;
	logic [SLOT_W-1:0]   keyword_slot = '0;
	logic [POS_W-1:0]    char_position = '0;
	logic [KLEN_W-1:0]   keyword_length = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [START_W-1:0]  line_start;
	logic [LENGTH_W-1:0] line_length;
	logic                hide_line;
	logic                last_line;
	logic                buffer_modified;
	logic                overflow;

	// classifier state
	logic [BYTE_W-1:0]   kw_chars [KW_SLOTS][KW_CHARS];
	logic [KLEN_W-1:0]   kw_len [KW_SLOTS];
	logic [KW_CHARS-1:0] shift_vec [KW_SLOTS];
	logic [ACTIVE_W-1:0] active_cfg = ACTIVE_RESET;
	logic [BYTE_W-1:0]   term_cfg = TERM_RESET;
	bit                  line_hit = 1'b0;
	bit                  any_hit = 1'b0;
	bit                  buf_over = 1'b0;
	int                  byte_pos = 0;
	int                  line_begin = 0;

	res_t                expected_lines [$];
	logic [BYTE_W-1:0]   text_q [$];
	row_t                script [SCRIPT_ROWS];
	int                  mismatches = 0;
	int                  cycle_count = 0;
	bit                  steady = 1'b0;

	keyword_line_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.opcode(opcode),
		.byte_value(byte_value),
		.end_of_buffer(end_of_buffer),
		.keyword_slot(keyword_slot),
		.char_position(char_position),
		.keyword_length(keyword_length),
		.empty(empty),
		.pop(pop),
		.line_start(line_start),
		.line_length(line_length),
		.hide_line(hide_line),
		.last_line(last_line),
		.buffer_modified(buffer_modified),
		.overflow(overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[keyword_line_filter] ERROR");
			$finish;
		end
	end

	initial begin
		for (int s = 0; s < KW_SLOTS; s++) begin
			kw_len[s] = '1;
			shift_vec[s] = '0;
			for (int p = 0; p < KW_CHARS; p++)
				kw_chars[s][p] = '0;
		end
	end

	// applies a keyword write, or runs a byte through every keyword slot and reports the line when it closes
	task automatic classify_item(input item_t it, output bit produced, output res_t r);
		int here;
		int n;
		int act;
		logic [KW_CHARS-1:0] nv;
		bit prev;
		produced = 1'b0;
		r = '0;
		case (it.op)
			OP_CHAR: kw_chars[it.slot][it.pos] = it.data;
			OP_LEN: kw_len[it.slot] = it.klen;
			OP_BYTE: begin
				here = byte_pos;
				if (here >= MAX_BYTES) begin
					buf_over = 1'b1;
					here = MAX_BYTES - 1;
				end
				byte_pos = here + 1;
				act = (active_cfg > KW_SLOTS) ? KW_SLOTS : active_cfg;
				for (int s = 0; s < KW_SLOTS; s++) begin
					n = (kw_len[s] > KW_CHARS) ? KW_CHARS : kw_len[s];
					nv = '0;
					for (int i = 0; i < n; i++) begin
						prev = (i == 0) ? 1'b1 : shift_vec[s][i-1];
						if (prev && kw_chars[s][i] == it.data)
							nv[i] = 1'b1;
					end
					shift_vec[s] = nv;
					if (n != 0 && nv[n-1] && s < act)
						line_hit = 1'b1;
				end
				if (it.eob || it.data == term_cfg) begin
					if (line_hit)
						any_hit = 1'b1;
					produced = 1'b1;
					r.line_start = START_W'(line_begin);
					r.line_length = LENGTH_W'(here - line_begin + 1);
					r.hide_line = line_hit;
					r.last_line = it.eob;
					r.buffer_modified = it.eob && any_hit;
					r.overflow = buf_over;
					for (int s = 0; s < KW_SLOTS; s++)
						shift_vec[s] = '0;
					line_hit = 1'b0;
					if (it.eob) begin
						byte_pos = 0;
						line_begin = 0;
						any_hit = 1'b0;
						buf_over = 1'b0;
					end else begin
						line_begin = (here + 1 >= MAX_BYTES) ? MAX_BYTES - 1 : here + 1;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic item_t make_item(input logic [OPCODE_W-1:0] op, input logic [7:0] data,
			input logic eob, input logic [2:0] slot, input logic [3:0] pos, input logic [4:0] klen);
		item_t it;
		it.op = op;
		it.data = data;
		it.eob = eob;
		it.slot = slot;
		it.pos = pos;
		it.klen = klen;
		return it;
	endfunction

	function automatic row_t cmd_row(input logic [OPCODE_W-1:0] op, input logic [7:0] data,
			input logic eob, input logic [2:0] slot, input logic [3:0] pos, input logic [4:0] klen);
		row_t rw;
		rw.it = make_item(op, data, eob, slot, pos, klen);
		rw.typed = 1'b0;
		rw.want = '0;
		return rw;
	endfunction

	function automatic row_t line_row(input logic [7:0] data, input logic eob,
			input int start, input int len, input logic hide, input logic last, input logic bmod);
		row_t rw;
		rw.it = make_item(OP_BYTE, data, eob, 3'd0, 4'd0, 5'd0);
		rw.typed = 1'b1;
		rw.want.line_start = START_W'(start);
		rw.want.line_length = LENGTH_W'(len);
		rw.want.hide_line = hide;
		rw.want.last_line = last;
		rw.want.buffer_modified = bmod;
		rw.want.overflow = 1'b0;
		return rw;
	endfunction

	function automatic logic [7:0] letter();
		return 8'h61 + 8'($urandom_range(0, 7));
	endfunction

	// mostly text built from keywords, terminators and letters, with some keyword rewrites and noise
	function automatic item_t random_item();
		item_t it;
		int r;
		int s;
		int n;
		it = make_item(OP_BYTE, 8'($urandom), 1'($urandom), 3'($urandom), 4'($urandom),
			5'($urandom));
		r = $urandom_range(0, 99);
		if (r < 4) begin
			it.op = OP_CHAR;
			if ($urandom_range(0, 3) != 0)
				it.data = letter();
		end else if (r < 7) begin
			it.op = OP_LEN;
			if ($urandom_range(0, 99) < 70)
				it.klen = 5'($urandom_range(1, 6));
		end else if (r < 9) begin
			it.op = OP_NONE;
		end else begin
			it.eob = ($urandom_range(0, 99) < 3);
			if (text_q.size() == 0) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					text_q.push_back(term_cfg);
				end else if (r < 25) begin
					s = $urandom_range(0, KW_SLOTS - 1);
					n = (kw_len[s] > KW_CHARS) ? KW_CHARS : kw_len[s];
					for (int i = 0; i < n; i++)
						text_q.push_back(kw_chars[s][i]);
				end else if (r < 30) begin
					text_q.push_back(8'($urandom));
				end
				if (text_q.size() == 0)
					text_q.push_back(letter());
			end
			it.data = text_q.pop_front();
		end
		return it;
	endfunction

	task automatic send_item(input item_t it, output bit produced, output res_t r);
		push <= 1'b1;
		opcode <= it.op;
		byte_value <= it.data;
		end_of_buffer <= it.eob;
		keyword_slot <= it.slot;
		char_position <= it.pos;
		keyword_length <= it.klen;
		@(negedge clk);
		while (full)
			@(negedge clk);
		@(posedge clk);
		classify_item(it, produced, r);
	endtask

	task automatic sender_pause();
		if (!steady && $urandom_range(0, 99) < 13) begin
			push <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 13);
		end
	endtask

	task automatic feed(input item_t it);
		bit produced;
		res_t r;
		send_item(it, produced, r);
		if (produced)
			expected_lines.push_back(r);
		sender_pause();
	endtask

	task automatic settle();
		push <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [7:0] value);
		logic [PDATA_W-1:0] wdata;
		wdata = $urandom();
		if (sel == REG_ACTIVE)
			wdata[ACTIVE_W-1:0] = value[ACTIVE_W-1:0];
		else
			wdata[BYTE_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_ACTIVE)
			active_cfg = wdata[ACTIVE_W-1:0];
		else
			term_cfg = wdata[BYTE_W-1:0];
		@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= steady || ($urandom_range(0, 99) >= 13);
		end
	end

	task automatic report_mismatch(input string why, input res_t want, input res_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("line mismatch (%s): expected start=%0d len=%0d hide=%0b last=%0b mod=%0b",
				why, want.line_start, want.line_length, want.hide_line, want.last_line,
				want.buffer_modified);
			$display("  expected ovf=%0b, got start=%0d len=%0d hide=%0b last=%0b mod=%0b ovf=%0b",
				want.overflow, got.line_start, got.line_length, got.hide_line,
				got.last_line, got.buffer_modified, got.overflow);
		end
	endtask

	// outputs only move at the rising edge, so the falling edge sees what the next edge takes
	always @(negedge clk) begin : check_lines
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got.line_start = line_start;
			got.line_length = line_length;
			got.hide_line = hide_line;
			got.last_line = last_line;
			got.buffer_modified = buffer_modified;
			got.overflow = overflow;
			if (expected_lines.size() == 0) begin
				report_mismatch("no line pending", '0, got);
			end else begin
				want = expected_lines.pop_front();
				if (got !== want)
					report_mismatch("wrong field", want, got);
			end
		end
	end

	initial begin : stimulus
		bit produced;
		res_t r;
		logic [3:0] act_v;
		logic [7:0] term_v;

		// slot 0 becomes "ab", slot 1 empty, slot 2 over-long, slot 7 ends in 0xff
		script = '{
			cmd_row(OP_LEN, 8'h00, 1'b0, 3'd0, 4'd0, 5'd2),
			cmd_row(OP_LEN, 8'h00, 1'b0, 3'd1, 4'd0, 5'd0),
			cmd_row(OP_LEN, 8'h00, 1'b0, 3'd2, 4'd0, 5'd31),
			cmd_row(OP_CHAR, 8'hff, 1'b0, 3'd7, 4'd15, 5'd0),
			cmd_row(OP_LEN, 8'h00, 1'b0, 3'd7, 4'd0, 5'd16),
			cmd_row(OP_BYTE, 8'h61, 1'b0, 3'd0, 4'd0, 5'd0),
			cmd_row(OP_BYTE, 8'h62, 1'b0, 3'd0, 4'd0, 5'd0),
			line_row(NEWLINE, 1'b0, 0, 3, 1'b1, 1'b0, 1'b0),
			cmd_row(OP_BYTE, 8'h00, 1'b0, 3'd0, 4'd0, 5'd0),
			line_row(NEWLINE, 1'b1, 3, 2, 1'b0, 1'b1, 1'b1),
			line_row(8'hff, 1'b1, 0, 1, 1'b0, 1'b1, 1'b0),
			cmd_row(OP_NONE, 8'h61, 1'b1, 3'd7, 4'd15, 5'd31),
			line_row(NEWLINE, 1'b0, 0, 1, 1'b0, 1'b0, 1'b0),
			cmd_row(OP_BYTE, 8'h62, 1'b0, 3'd0, 4'd0, 5'd0),
			cmd_row(OP_BYTE, 8'h63, 1'b0, 3'd0, 4'd0, 5'd0),
			cmd_row(OP_BYTE, 8'h61, 1'b0, 3'd0, 4'd0, 5'd0),
			// keyword rewritten mid-line, the partial match survives
			cmd_row(OP_CHAR, 8'h7a, 1'b0, 3'd0, 4'd1, 5'd0),
			cmd_row(OP_BYTE, 8'h7a, 1'b0, 3'd0, 4'd0, 5'd0),
			cmd_row(OP_BYTE, 8'h61, 1'b1, 3'd0, 4'd0, 5'd0)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_ACTIVE, 8'd15);

		// every keyword character is written before the first byte
		for (int s = 0; s < KW_SLOTS; s++)
			for (int p = 0; p < KW_CHARS; p++)
				feed(make_item(OP_CHAR, 8'h61 + 8'(s + p), 1'($urandom), 3'(s), 4'(p),
					5'($urandom)));

		for (int k = 0; k < SCRIPT_ROWS; k++) begin
			send_item(script[k].it, produced, r);
			if (script[k].typed)
				expected_lines.push_back(script[k].want);
			else if (produced)
				expected_lines.push_back(r);
			sender_pause();
		end
		settle();

		// one buffer past the byte limit: a full-size line, then saturated offsets
		steady = 1'b1;
		for (int i = 0; i < MAX_BYTES - 1; i++)
			feed(make_item(OP_BYTE, letter(), 1'b0, 3'($urandom), 4'($urandom), 5'($urandom)));
		feed(make_item(OP_BYTE, NEWLINE, 1'b0, 3'd0, 4'd0, 5'd0));
		feed(make_item(OP_BYTE, letter(), 1'b0, 3'd0, 4'd0, 5'd0));
		feed(make_item(OP_BYTE, NEWLINE, 1'b0, 3'd0, 4'd0, 5'd0));
		feed(make_item(OP_BYTE, letter(), 1'b1, 3'd0, 4'd0, 5'd0));
		settle();
		steady = 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					act_v = 4'd15;
					term_v = NEWLINE;
				end
				1: begin
					act_v = 4'd0;
					term_v = 8'h00;
				end
				2: begin
					act_v = 4'd8;
					term_v = 8'hff;
				end
				3: begin
					act_v = 4'd1;
					term_v = letter();
				end
				default: begin
					act_v = 4'($urandom_range(0, 15));
					term_v = ($urandom_range(0, 1) != 0) ? letter() : 8'($urandom);
				end
			endcase
			write_reg(REG_ACTIVE, {4'd0, act_v});
			write_reg(REG_TERM, term_v);
			steady = (ph == 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				feed(random_item());
			feed(make_item(OP_BYTE, letter(), 1'b1, 3'($urandom), 4'($urandom), 5'($urandom)));
			settle();
			steady = 1'b0;
		end

		if (mismatches == 0 && expected_lines.size() == 0) begin
			$display("[keyword_line_filter] OK");
		end else begin
			$display("[keyword_line_filter] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
